// File: rtl/fraction_arith_unit_macros.svh
// ----------------------------------------------------------------------------
// fraction_arith_unit_macros
// Assertion macros for the fraction arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef FRACTION_ARITH_UNIT_MACROS_SVH
`define FRACTION_ARITH_UNIT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define FAU_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent.
`define FAU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/fau_pkg.sv
// ----------------------------------------------------------------------------
// fau_pkg
// Shared types and codes for the fraction arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package fau_pkg;

  localparam int unsigned DW = 32;

  typedef enum logic [2:0] {
    CMD_REDUCE = 3'd0,
    CMD_RADD   = 3'd1,
    CMD_ADD    = 3'd2,
    CMD_SUB    = 3'd3,
    CMD_MUL    = 3'd4,
    CMD_DIV    = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_COMB,
    ST_EUC_START,
    ST_EUC_WAIT,
    ST_DN_START,
    ST_DN_WAIT,
    ST_DD_START,
    ST_DD_WAIT,
    ST_DONE
  } state_t;

  // Request to the shared divider.
  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
  } div_req_t;

  // Response from the shared divider.
  typedef struct packed {
    logic          done;
    logic [DW-1:0] quot;
    logic [DW-1:0] rem;
  } div_rsp_t;

endpackage
`default_nettype wire

// File: rtl/fraction_arith_unit.sv
// Add, subtract, multiply and divide pass three times through one shared
// 32x32 multiplier and then a combine state before the result is offered.
// Reducing commands (reduce, reducing add) then run Euclid remainder steps and
// two divisions on the shared divider; reduce skips the multiplier. Only one item
// is in flight; a new item is taken the cycle after the result leaves.
// Reset: synchronous, active high; clears the sequencer.
// ----------------------------------------------------------------------------
// fraction_arith_unit
// Rational arithmetic on two signed fractions with Euclid reduction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fraction_arith_unit_macros.svh"
module fraction_arith_unit
  import fau_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [2:0]    command,
  input  wire logic [DW-1:0] num_a,
  input  wire logic [DW-1:0] den_a,
  input  wire logic [DW-1:0] num_b,
  input  wire logic [DW-1:0] den_b,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [DW-1:0]      res_num,
  output logic [DW-1:0]      res_den,
  output logic               status
);

  state_t state;
  state_t state_next;

  // Operand registers for the item in flight.
  logic [2:0]    cmd;
  logic [DW-1:0] na, da, nb, db;
  // Products from the shared multiplier.
  logic [DW-1:0] p0, p1;
  // Fraction to reduce, and the Euclid pair.
  logic [DW-1:0] rn, rd, ex, ey;

  // Shared multiplier: one product per cycle, operands chosen by the state.
  logic [DW-1:0] mul_x, mul_y, mul_p;
  logic [DW-1:0] mul_r;

  div_req_t req;
  div_rsp_t rsp;

  fau_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // For add forms: p0 = na*db, p1 = da*nb, then da*db.
  // Multiply: p0 = na*nb, then da*db. Divide: p0 = na*db, p1 = da*nb.
  always_comb begin
    mul_x = na;
    mul_y = db;
    unique case (state)
      ST_MUL0: begin
        mul_x = na;
        mul_y = (cmd == CMD_MUL) ? nb : db;
      end
      ST_MUL1: begin
        mul_x = da;
        mul_y = nb;
      end
      ST_MUL2: begin
        mul_x = da;
        mul_y = db;
      end
      default: begin
        mul_x = na;
        mul_y = db;
      end
    endcase
    mul_p = DW'(mul_x * mul_y);
  end

  always_ff @(posedge clk) begin
    mul_r <= mul_p;
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (command == CMD_REDUCE) ? ST_COMB : ST_MUL0;
        end
      end
      ST_MUL0:      state_next = ST_MUL1;
      ST_MUL1:      state_next = ST_MUL2;
      ST_MUL2:      state_next = ST_COMB;
      ST_COMB: begin
        if ((cmd == CMD_REDUCE) || (cmd == CMD_RADD)) begin
          state_next = ST_EUC_START;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_EUC_START: state_next = (rd == '0) ? ST_DONE : ST_EUC_WAIT;
      ST_EUC_WAIT: begin
        if (rsp.done) begin
          state_next = (rsp.rem == '0) ? ST_DN_START : ST_EUC_WAIT;
        end
      end
      ST_DN_START:  state_next = ST_DN_WAIT;
      ST_DN_WAIT:   state_next = rsp.done ? ST_DD_START : ST_DN_WAIT;
      ST_DD_START:  state_next = ST_DD_WAIT;
      ST_DD_WAIT:   state_next = rsp.done ? ST_DONE : ST_DD_WAIT;
      ST_DONE:      state_next = out_ready ? ST_IDLE : ST_DONE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Output and divider request decode. Each Euclid request is built from the
  // values that the pair registers take at the same edge.
  always_comb begin
    in_ready     = (state == ST_IDLE);
    out_valid    = (state == ST_DONE);
    req.start    = 1'b0;
    req.dividend = ex;
    req.divisor  = ey;
    unique case (state)
      ST_EUC_START: begin
        req.start    = (rd != '0);
        req.dividend = rn;
        req.divisor  = rd;
      end
      ST_EUC_WAIT: begin
        req.start    = rsp.done && (rsp.rem != '0);
        req.dividend = ey;
        req.divisor  = rsp.rem;
      end
      ST_DN_START: begin
        req.start    = 1'b1;
        req.dividend = rn;
      end
      ST_DD_START: begin
        req.start    = 1'b1;
        req.dividend = rd;
      end
      default: req.start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd <= command;
          na  <= num_a;
          da  <= den_a;
          nb  <= num_b;
          db  <= den_b;
          rn  <= num_a;
          rd  <= den_a;
        end
      end
      ST_MUL1: p0 <= mul_r;
      ST_MUL2: p1 <= mul_r;
      ST_COMB: begin
        // The third product lands here; combine per command.
        if (cmd != CMD_REDUCE) begin
          rd <= mul_r;
          unique case (cmd) inside
            CMD_SUB: begin
              rn <= p0 - p1;
            end
            CMD_MUL: begin
              rn <= p0;
            end
            CMD_DIV: begin
              rn <= p0;
              rd <= p1;
            end
            CMD_RADD, CMD_ADD: begin
              rn <= p0 + p1;
            end
            default: begin
              rn <= '0;
              rd <= '0;
            end
          endcase
        end
        status <= 1'b0;
      end
      ST_EUC_START: begin
        ex <= rn;
        ey <= rd;
        if (rd == '0) begin
          rn     <= '0;
          status <= 1'b1;
        end
      end
      ST_EUC_WAIT: begin
        // Euclid step: (x, y) <- (y, x rem y) until the remainder is zero.
        if (rsp.done && (rsp.rem != '0)) begin
          ex <= ey;
          ey <= rsp.rem;
        end
      end
      ST_DN_WAIT: if (rsp.done) rn <= rsp.quot;
      ST_DD_WAIT: if (rsp.done) rd <= rsp.quot;
      default: begin
      end
    endcase
  end

  assign res_num = rn;
  assign res_den = rd;

  `FAU_ASSERT_IMPL(a_ready_idle, clk, rst, in_ready && out_valid, 1'b0,
                   "ready and valid together")
  `FAU_ASSERT_IMPL(a_err_zero, clk, rst, out_valid && status,
                   (res_num == '0) && (res_den == '0), "error result not zero")
  `FAU_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid,
                   "result dropped")

endmodule
`default_nettype wire

// File: rtl/fau_divider.sv
// ----------------------------------------------------------------------------
// fau_divider
// Radix-2 signed divider with truncating quotient and remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module fau_divider
  import fau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DW-1:0]         rem_q;
  logic [DW-1:0]         quo_q;
  logic [DW-1:0]         dvs;
  logic [$clog2(DW)-1:0] cnt;
  logic                  busy;
  logic                  done;
  logic                  neg_q;
  logic                  neg_r;
  logic [DW:0]           trial;
  logic [DW-1:0]         rem_sh;

  // The remainder is shifted one bit and the divisor trial subtracted.
  always_comb begin
    rem_sh = {rem_q[DW-2:0], quo_q[DW-1]};
    trial  = {1'b0, rem_sh} - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        rem_q <= '0;
        quo_q <= req.dividend[DW-1] ? (~req.dividend + 1'b1) : req.dividend;
        dvs   <= req.divisor[DW-1] ? (~req.divisor + 1'b1) : req.divisor;
        neg_q <= req.dividend[DW-1] ^ req.divisor[DW-1];
        neg_r <= req.dividend[DW-1];
      end else if (busy) begin
        if (!trial[DW]) begin
          rem_q <= trial[DW-1:0];
          quo_q <= {quo_q[DW-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[DW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (&cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.quot = neg_q ? (~quo_q + 1'b1) : quo_q;
    rsp.rem  = neg_r ? (~rem_q + 1'b1) : rem_q;
  end

endmodule
`default_nettype wire
